@@ design/rmst_pkg.sv @@
// ----------------------------------------------------------------------------
// rmst_pkg: shared types and constants of the range minimum segment tree
// Holds the field widths, the identity value, the operation codes and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package rmst_pkg;

   localparam int VALUE_W = 30;
   localparam int POS_W   = 10;
   localparam int BOUND_W = 11;

   localparam logic [VALUE_W-1:0] IDENTITY = 30'd1000000000;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef enum logic [5:0] {
      ST_CLEAR   = 6'b000001,
      ST_IDLE    = 6'b000010,
      ST_UPDATE  = 6'b000100,
      ST_Q_LEFT  = 6'b001000,
      ST_Q_RIGHT = 6'b010000,
      ST_Q_FIN   = 6'b100000
   } state_type;

   function automatic logic [VALUE_W-1:0] min_val(input logic [VALUE_W-1:0] a,
                                                  input logic [VALUE_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

`default_nettype wire

@@ design/rmst_if.sv @@
// ----------------------------------------------------------------------------
// rmst_if: request and response channels of the range minimum segment tree
// Valid/ready channels; a transfer takes place when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmst_req_if import rmst_pkg::*; ();
   logic                valid;
   logic                ready;
   op_type              op;
   logic [POS_W-1:0]    position;
   logic [BOUND_W-1:0]  end_bound;
   logic [VALUE_W-1:0]  new_value;

   modport source (output valid, op, position, end_bound, new_value, input ready);
   modport sink   (input valid, op, position, end_bound, new_value, output ready);
endinterface

interface rmst_rsp_if import rmst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  range_min;

   modport source (output valid, range_min, input ready);
   modport sink   (input valid, range_min, output ready);
endinterface

`default_nettype wire

@@ design/rmst_mem.sv @@
// ----------------------------------------------------------------------------
// rmst_mem: tree node store
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rmst_mem #(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 30
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ design/range_min_segment_tree_core.sv @@
// Updates write the leaf and then its ancestors, one tree level a cycle; a
// query treats the left and the right bound in separate states at each
// level, as the single read port of the node store serves at most one node
// a cycle. One item is worked on at a time.
// Reset: a clearing pass writes the identity to every node; no request is
// taken until it has finished.
// ----------------------------------------------------------------------------
// range_min_segment_tree_core: bottom-up segment tree of range minima
// Point updates rewrite one leaf and its ancestors; queries return the
// minimum over a half-open leaf range from a single node memory.
// ----------------------------------------------------------------------------
`default_nettype none

module range_min_segment_tree_core import rmst_pkg::*; #(
   parameter int LEAVES = 1024
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rmst_req_if.sink   req_ch,
   rmst_rsp_if.source rsp_ch
);

   // Node k has children 2k and 2k+1; leaf p sits at node LEAVES+p.
   localparam int DEPTH  = 2 * LEAVES;
   localparam int ADDR_W = $clog2(DEPTH);
   // Query bounds can reach 2*LEAVES itself, hence one more value.
   localparam int IDX_W  = $clog2(DEPTH + 1);
   localparam int CW     = (IDX_W > BOUND_W) ? IDX_W : BOUND_W;

   localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] ROOT_NODE = ADDR_W'(1);
   localparam logic [CW-1:0]     LEAVES_C  = CW'(LEAVES);

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [ADDR_W-1:0]   node_ff, node_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [IDX_W-1:0]    lo_ff, lo_in;
   logic [IDX_W-1:0]    hi_ff, hi_in;
   logic [VALUE_W-1:0]  acc_l_ff, acc_l_in;
   logic [VALUE_W-1:0]  acc_r_ff, acc_r_in;
   logic                pend_ff, pend_in;
   logic                pend_right_ff, pend_right_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [VALUE_W-1:0]  wr_data;
   logic                rd_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [VALUE_W-1:0]  rd_data;

   logic                req_xfer;
   logic [CW-1:0]       pos_ext;
   logic [CW-1:0]       bound_ext;
   logic [CW-1:0]       right_clamped;
   logic [ADDR_W-1:0]   leaf_node;
   logic [VALUE_W-1:0]  sat_value;
   logic [ADDR_W-1:0]   parent;
   logic [VALUE_W-1:0]  parent_val;
   logic [IDX_W-1:0]    hi_dec;

   rmst_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (VALUE_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Requests are taken only from the idle state; a waiting result does not
   // block them, because the response register parts the two channels.
   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign req_xfer        = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.range_min = rsp_data_ff;

   // Request decoding: leaf address, saturated value and the clamped
   // right bound of a query.
   assign pos_ext       = CW'(req_ch.position);
   assign bound_ext     = CW'(req_ch.end_bound);
   assign right_clamped = (bound_ext > LEAVES_C) ? LEAVES_C : bound_ext;
   assign leaf_node     = ADDR_W'(pos_ext + LEAVES_C);
   assign sat_value     = (req_ch.new_value > IDENTITY) ? IDENTITY : req_ch.new_value;

   // On the way up, one child of each parent is the value just written and
   // the other is the sibling read in the previous cycle. The sibling is
   // never the node written in the same cycle, so no forwarding is needed.
   assign parent     = node_ff >> 1;
   assign parent_val = min_val(val_ff, rd_data);
   assign hi_dec     = hi_ff - IDX_W'(1);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      node_in       = node_ff;
      val_in        = val_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      acc_l_in      = acc_l_ff;
      acc_r_in      = acc_r_ff;
      pend_in       = 1'b0;
      pend_right_in = pend_right_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_data       = IDENTITY;
      rd_en         = 1'b0;
      rd_addr       = node_ff;

      // A node read in the previous query cycle is folded into its side.
      if (pend_ff) begin
         if (pend_right_ff) begin
            acc_r_in = min_val(rd_data, acc_r_ff);
         end else begin
            acc_l_in = min_val(acc_l_ff, rd_data);
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = IDENTITY;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_xfer) begin
               if (req_ch.op == OP_UPDATE) begin
                  // A position beyond the leaves writes nothing.
                  if (pos_ext < LEAVES_C) begin
                     wr_en    = 1'b1;
                     wr_addr  = leaf_node;
                     wr_data  = sat_value;
                     rd_en    = 1'b1;
                     rd_addr  = leaf_node ^ ADDR_W'(1);
                     node_in  = leaf_node;
                     val_in   = sat_value;
                     state_in = ST_UPDATE;
                  end
               end else begin
                  acc_l_in = IDENTITY;
                  acc_r_in = IDENTITY;
                  // An empty or inverted range starts with lo equal to hi,
                  // so the walk ends at once and returns the identity.
                  if (pos_ext < right_clamped) begin
                     lo_in = IDX_W'(pos_ext + LEAVES_C);
                     hi_in = IDX_W'(right_clamped + LEAVES_C);
                  end else begin
                     lo_in = '0;
                     hi_in = '0;
                  end
                  state_in = ST_Q_LEFT;
               end
            end
         end

         ST_UPDATE: begin
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = parent_val;
            if (parent > ROOT_NODE) begin
               rd_en   = 1'b1;
               rd_addr = parent ^ ADDR_W'(1);
               node_in = parent;
               val_in  = parent_val;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_Q_LEFT: begin
            if (lo_ff < hi_ff) begin
               if (lo_ff[0]) begin
                  rd_en         = 1'b1;
                  rd_addr       = lo_ff[ADDR_W-1:0];
                  pend_in       = 1'b1;
                  pend_right_in = 1'b0;
                  lo_in         = lo_ff + IDX_W'(1);
               end
               state_in = ST_Q_RIGHT;
            end else begin
               state_in = ST_Q_FIN;
            end
         end

         ST_Q_RIGHT: begin
            if (hi_ff[0]) begin
               rd_en         = 1'b1;
               rd_addr       = hi_dec[ADDR_W-1:0];
               pend_in       = 1'b1;
               pend_right_in = 1'b1;
            end
            // With hi odd, (hi - 1) >> 1 equals hi >> 1.
            lo_in    = lo_ff >> 1;
            hi_in    = hi_ff >> 1;
            state_in = ST_Q_LEFT;
         end

         ST_Q_FIN: begin
            // Wait here until the response register is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = min_val(acc_l_ff, acc_r_ff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      val_ff        <= val_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      acc_l_ff      <= acc_l_in;
      acc_r_ff      <= acc_r_in;
      pend_right_ff <= pend_right_in;
      rsp_data_ff   <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // Queries only read the node store.
   a_no_write_in_query: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_LEFT || state_ff == ST_Q_RIGHT || state_ff == ST_Q_FIN)
      |-> !wr_en)
      else $error("node store written during a query");

   // The upward walk stops once the root has been written.
   a_update_below_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (node_ff > ROOT_NODE))
      else $error("update walk went past the root");

   // A read issued in a query cycle is folded in the very next cycle.
   a_pend_follows_read: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(rd_en) && $past(state_ff == ST_Q_LEFT || state_ff == ST_Q_RIGHT))
      else $error("pending fold without a matching query read");

   // Query bounds stay inside the node store.
   a_bounds_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_LEFT || state_ff == ST_Q_RIGHT)
      |-> (hi_ff <= IDX_W'(DEPTH)) && (lo_ff <= IDX_W'(DEPTH)))
      else $error("query bound beyond the node store");

   // Results never exceed the identity value.
   a_result_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff <= IDENTITY))
      else $error("range minimum above the identity value");
`endif

endmodule

`default_nettype wire
